FILE: rtl/mtt_pkg.sv
// shared types and constants for the midi tick to microsecond tempo map
// no dependencies
package mtt_pkg;

  localparam int unsigned TickW  = 32;
  localparam int unsigned TempoW = 24;
  localparam int unsigned PpqnW  = 15;
  localparam int unsigned UsW    = 63;
  localparam int unsigned ProdW  = TickW + TempoW;
  localparam int unsigned CfgW   = 24;

  typedef enum logic [1:0] {
    OpClear   = 2'd0,
    OpAppend  = 2'd1,
    OpConvert = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StOrder    = 2'd2,
    StReserved = 2'd3
  } status_e;

  typedef enum logic {
    CfgPpqn  = 1'b0,
    CfgTempo = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [TickW-1:0]  pulse;
    logic [TempoW-1:0] tempo;
  } req_t;

  typedef struct packed {
    logic [UsW-1:0] microseconds;
    logic [1:0]     status;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [TickW-1:0]  ticks;
    logic [TempoW-1:0] tempo;
  } seg_req_t;

endpackage

FILE: rtl/mtt_seg_div.sv
// segment unit: floor(ticks * tempo / ppqn), one quotient bit per cycle
// depends on mtt_pkg
module mtt_seg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mtt_pkg::seg_req_t         seg_i,
  input  logic [mtt_pkg::PpqnW-1:0] ppqn_i,
  output logic                      done_o,
  output logic [mtt_pkg::ProdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(mtt_pkg::ProdW + 1);

  logic [mtt_pkg::ProdW-1:0] p_q, p_d;
  logic [mtt_pkg::PpqnW-1:0] rem_q, rem_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [mtt_pkg::PpqnW-1:0] div_w;
  logic [mtt_pkg::PpqnW:0]   rem_sh;

  // zero ppqn counts as one
  assign div_w  = (ppqn_i == '0) ? mtt_pkg::PpqnW'(1) : ppqn_i;
  assign rem_sh = {rem_q, p_q[mtt_pkg::ProdW-1]};

  always_comb begin
    p_d    = p_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (seg_i.start) begin
      p_d   = mtt_pkg::ProdW'(seg_i.ticks) * mtt_pkg::ProdW'(seg_i.tempo);
      rem_d = '0;
      cnt_d = CntW'(mtt_pkg::ProdW);
    end else if (cnt_q != '0) begin
      if (rem_sh >= {1'b0, div_w}) begin
        rem_d = mtt_pkg::PpqnW'(rem_sh - {1'b0, div_w});
        p_d   = {p_q[mtt_pkg::ProdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[mtt_pkg::PpqnW-1:0];
        p_d   = {p_q[mtt_pkg::ProdW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = p_q;

endmodule

FILE: rtl/midi_tick_to_microsecond_tempo_map_top.sv
// top level of the midi tempo map: table memory, sequencer, result register
// depends on mtt_pkg and mtt_seg_div
//
// usage
// - a request is taken at a rising edge with start_i high and busy_o low
// - op clear empties the map, op append adds a tempo change in ascending
//   tick order, op convert turns a tick position into microseconds
// - each request gives exactly one result, shown on result_o for one cycle
//   with result_valid_o high; the receiver cannot stall, so it must take it
// - clear and unused op codes: result shown in the cycle after the request
// - append: result shown after one memory read of the last entry, then the
//   decision; on an empty map the entry is written at once, as for clear
// - convert: per segment a memory read of the next change, a divide in the
//   shared segment unit (the multiply folds into its load) and an
//   accumulate, once for each stored change below the query and once more
//   for the final segment, which needs no read when the map is empty or
//   every stored change lies below the query
// - busy_o stays high until the result is issued; the next request may be
//   taken in the cycle the result is shown
// - config writes (ppqn, default tempo) via cfg_we_i while idle
// - reset clears the entry count and the config to 480 and 500000; the
//   table memory needs no clearing since only counted entries are read
module midi_tick_to_microsecond_tempo_map_top #(
  parameter int unsigned MAX_TEMPO_CHANGES = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  mtt_pkg::req_t           req_i,
  output logic                    result_valid_o,
  output mtt_pkg::res_t           result_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [mtt_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned AW   = (MAX_TEMPO_CHANGES > 1) ? $clog2(MAX_TEMPO_CHANGES) : 1;
  localparam int unsigned CntW = $clog2(MAX_TEMPO_CHANGES + 1);
  localparam int unsigned EntW = mtt_pkg::TickW + mtt_pkg::TempoW;

  typedef enum logic [1:0] {
    Idle,
    AppRead,
    CvRead,
    CvDiv
  } state_e;

  state_e state_q, state_d;

  // config
  logic [mtt_pkg::PpqnW-1:0]  ppqn_q;
  logic [mtt_pkg::TempoW-1:0] dflt_q;

  // table memory: tick in upper bits, tempo in lower bits
  logic [EntW-1:0] mem [MAX_TEMPO_CHANGES];
  logic [EntW-1:0] rdata_q;
  logic [AW-1:0]   raddr, waddr;
  logic            we;
  logic [EntW-1:0] wdata;
  logic [mtt_pkg::TickW-1:0]  rd_tick;
  logic [mtt_pkg::TempoW-1:0] rd_tempo;

  // walk state
  mtt_pkg::req_t              req_q, req_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            idx_q, idx_d;
  logic [mtt_pkg::TickW-1:0]  last_q, last_d;
  logic [mtt_pkg::TempoW-1:0] cur_q, cur_d;
  logic [mtt_pkg::UsW-1:0]    acc_q, acc_d;
  logic                       final_q, final_d;
  logic                       rv_q, rv_d;
  mtt_pkg::res_t              res_q, res_d;

  // segment unit
  mtt_pkg::seg_req_t          seg;
  logic                       seg_done;
  logic [mtt_pkg::ProdW-1:0]  seg_quot;
  logic [mtt_pkg::UsW:0]      sum_w;
  logic [mtt_pkg::UsW-1:0]    sum_sat;
  logic [CntW-1:0]            top_idx;

  assign rd_tick  = rdata_q[EntW-1 -: mtt_pkg::TickW];
  assign rd_tempo = rdata_q[mtt_pkg::TempoW-1:0];
  assign top_idx  = count_q - CntW'(1);

  // saturating accumulate of a finished segment
  assign sum_w   = {1'b0, acc_q} + (mtt_pkg::UsW + 1)'(seg_quot);
  assign sum_sat = sum_w[mtt_pkg::UsW] ? {mtt_pkg::UsW{1'b1}} : sum_w[mtt_pkg::UsW-1:0];

  mtt_seg_div u_seg_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .ppqn_i (ppqn_q),
    .done_o (seg_done),
    .quot_o (seg_quot)
  );

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    count_d = count_q;
    idx_d   = idx_q;
    last_d  = last_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    final_d = final_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    raddr   = '0;
    waddr   = '0;
    we      = 1'b0;
    wdata   = {req_q.pulse, req_q.tempo};
    seg     = '0;

    case (state_q)
      Idle: begin
        if (start_i) begin
          req_d = req_i;
          res_d = '0;
          case (mtt_pkg::op_e'(req_i.op))
            mtt_pkg::OpClear: begin
              count_d = '0;
              rv_d    = 1'b1;
            end
            mtt_pkg::OpAppend: begin
              if (count_q != '0) begin
                raddr   = top_idx[AW-1:0];
                state_d = AppRead;
              end else begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {req_i.pulse, req_i.tempo};
                count_d = CntW'(1);
                rv_d    = 1'b1;
              end
            end
            mtt_pkg::OpConvert: begin
              acc_d  = '0;
              last_d = '0;
              cur_d  = dflt_q;
              idx_d  = '0;
              if (count_q == '0) begin
                seg.start = 1'b1;
                seg.ticks = req_i.pulse;
                seg.tempo = dflt_q;
                final_d   = 1'b1;
                state_d   = CvDiv;
              end else begin
                raddr   = '0;
                state_d = CvRead;
              end
            end
            default: begin
              rv_d = 1'b1;
            end
          endcase
        end
      end

      AppRead: begin
        state_d = Idle;
        rv_d    = 1'b1;
        if (req_q.pulse == rd_tick) begin
          // same tick replaces the tempo of the last entry
          we    = 1'b1;
          waddr = top_idx[AW-1:0];
        end else if (req_q.pulse < rd_tick) begin
          res_d.status = mtt_pkg::StOrder;
        end else if (count_q >= CntW'(MAX_TEMPO_CHANGES)) begin
          res_d.status = mtt_pkg::StFull;
        end else begin
          we      = 1'b1;
          waddr   = count_q[AW-1:0];
          count_d = count_q + CntW'(1);
        end
      end

      CvRead: begin
        seg.start = 1'b1;
        seg.tempo = cur_q;
        state_d   = CvDiv;
        if (req_q.pulse > rd_tick) begin
          seg.ticks = rd_tick - last_q;
          cur_d     = rd_tempo;
          last_d    = rd_tick;
          idx_d     = idx_q + CntW'(1);
          final_d   = 1'b0;
        end else begin
          seg.ticks = req_q.pulse - last_q;
          final_d   = 1'b1;
        end
      end

      CvDiv: begin
        if (seg_done) begin
          acc_d = sum_sat;
          if (final_q) begin
            res_d.microseconds = sum_sat;
            rv_d               = 1'b1;
            state_d            = Idle;
          end else if (idx_q == count_q) begin
            // every change lies below the query: rest at the last tempo
            seg.start = 1'b1;
            seg.ticks = req_q.pulse - last_q;
            seg.tempo = cur_q;
            final_d   = 1'b1;
          end else begin
            raddr   = idx_q[AW-1:0];
            state_d = CvRead;
          end
        end
      end

      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      count_q <= '0;
      rv_q    <= 1'b0;
      ppqn_q  <= mtt_pkg::PpqnW'(480);
      dflt_q  <= mtt_pkg::TempoW'(500000);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        case (mtt_pkg::cfg_idx_e'(cfg_idx_i))
          mtt_pkg::CfgPpqn:  ppqn_q <= cfg_data_i[mtt_pkg::PpqnW-1:0];
          mtt_pkg::CfgTempo: dflt_q <= cfg_data_i[mtt_pkg::TempoW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    cur_q   <= cur_d;
    acc_q   <= acc_d;
    final_q <= final_d;
    res_q   <= res_d;
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign busy_o         = (state_q != Idle);
  assign result_valid_o = rv_q;
  assign result_o       = res_q;

endmodule

FILE: tb/tb.sv
// testbench for the midi tick to microsecond tempo map top level
// directed table plus sequence-shaped random requests, checked against an in-bench tempo map
// depends on mtt_pkg and midi_tick_to_microsecond_tempo_map_top
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxChanges = 256;
  localparam longint unsigned CycleLimit = 100_000_000;
  localparam logic [62:0] UsMax = '1;

  typedef struct packed {
    logic has;
    mtt_pkg::res_t val;
  } typed_t;

  typedef struct {
    mtt_pkg::req_t r;
    logic          has;
    mtt_pkg::res_t val;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  mtt_pkg::req_t req_i = '0;
  logic result_valid_o;
  mtt_pkg::res_t result_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [mtt_pkg::CfgW-1:0] cfg_data_i = '0;

  midi_tick_to_microsecond_tempo_map_top #(
    .MAX_TEMPO_CHANGES(MaxChanges)
  ) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i,
    .result_valid_o, .result_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // shadow of the tempo map and the two registers
  logic [mtt_pkg::TickW-1:0]  map_tick [MaxChanges];
  logic [mtt_pkg::TempoW-1:0] map_tempo [MaxChanges];
  int unsigned                map_count = 0;
  logic [mtt_pkg::PpqnW-1:0]  ppqn_q = 15'd480;
  logic [mtt_pkg::TempoW-1:0] dflt_tempo_q = 24'd500000;

  mtt_pkg::res_t result_q [$];   // results still to come, oldest first
  typed_t typed_q [$];           // hand-typed answers, one per request sent
  row_t   dir_rows [$];
  int     mismatches = 0;
  int     idle_pct = 0;
  int     req_count = 0;
  longint unsigned cycles = 0;

  // one segment: floor(ticks * tempo / ppqn), zero ppqn counts as one
  function automatic logic [63:0] seg_us(logic [mtt_pkg::TickW-1:0] ticks,
                                         logic [mtt_pkg::TempoW-1:0] tpo);
    logic [63:0] div;
    div = (ppqn_q == '0) ? 64'd1 : {49'd0, ppqn_q};
    return ({32'd0, ticks} * {40'd0, tpo}) / div;
  endfunction

  // applies one request to the shadow map and gives the result it should cause
  function automatic mtt_pkg::res_t tempo_map_predict(mtt_pkg::req_t r);
    mtt_pkg::res_t o;
    logic [63:0] acc;
    logic [mtt_pkg::TickW-1:0] last;
    logic [mtt_pkg::TempoW-1:0] cur;
    bit stop;
    o = '0;
    case (mtt_pkg::op_e'(r.op))
      mtt_pkg::OpClear: map_count = 0;
      mtt_pkg::OpAppend: begin
        if (map_count > 0 && r.pulse == map_tick[map_count-1]) begin
          map_tempo[map_count-1] = r.tempo;
        end else if (map_count > 0 && r.pulse < map_tick[map_count-1]) begin
          o.status = mtt_pkg::StOrder;
        end else if (map_count >= MaxChanges) begin
          o.status = mtt_pkg::StFull;
        end else begin
          map_tick[map_count] = r.pulse;
          map_tempo[map_count] = r.tempo;
          map_count++;
        end
      end
      mtt_pkg::OpConvert: begin
        acc = '0;
        last = '0;
        cur = dflt_tempo_q;
        stop = 1'b0;
        for (int i = 0; i < map_count && !stop; i++) begin
          if (r.pulse > map_tick[i]) begin
            acc += seg_us(map_tick[i] - last, cur);
            cur = map_tempo[i];
            last = map_tick[i];
          end else begin
            stop = 1'b1;
          end
        end
        acc += seg_us(r.pulse - last, cur);
        o.microseconds = (acc > {1'b0, UsMax}) ? UsMax : acc[62:0];
      end
      default: ;
    endcase
    return o;
  endfunction

  // accepted requests feed the shadow map; results are checked against the oldest entry
  always @(posedge clk_i) begin
    mtt_pkg::res_t exp_r;
    typed_t t;
    mtt_pkg::res_t p;
    if (rst_ni && result_valid_o) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        exp_r = result_q.pop_front();
        if (result_o.microseconds !== exp_r.microseconds ||
            result_o.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: us exp %0d got %0d, status exp %0d got %0d",
                     exp_r.microseconds, result_o.microseconds, exp_r.status, result_o.status);
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      t = typed_q.pop_front();
      p = tempo_map_predict(req_i);
      // hand-typed rows win over the shadow map's answer
      result_q = {result_q, (t.has ? t.val : p)};
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // present one request and hold it until taken; random gaps first
  task automatic send_req(mtt_pkg::req_t r, logic has, mtt_pkg::res_t val);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    typed_q = {typed_q, typed_t'{has, val}};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    req_count++;
  endtask

  task automatic send(mtt_pkg::op_e op, logic [mtt_pkg::TickW-1:0] pulse,
                      logic [mtt_pkg::TempoW-1:0] tpo);
    mtt_pkg::req_t r;
    r.op = op;
    r.pulse = pulse;
    r.tempo = tpo;
    send_req(r, 1'b0, '0);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [mtt_pkg::PpqnW-1:0] ppqn, logic [mtt_pkg::TempoW-1:0] tpo);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= mtt_pkg::CfgPpqn;
    cfg_data_i <= {9'd0, ppqn};
    @(posedge clk_i);
    cfg_idx_i <= mtt_pkg::CfgTempo;
    cfg_data_i <= tpo;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ppqn_q = ppqn;
    dflt_tempo_q = tpo;
    @(posedge clk_i);
  endtask

  task automatic add_row(mtt_pkg::op_e op, logic [31:0] pulse, logic [23:0] tpo, logic has,
                         logic [62:0] us, mtt_pkg::status_e st);
    row_t w;
    w.r.op = op;
    w.r.pulse = pulse;
    w.r.tempo = tpo;
    w.has = has;
    w.val.microseconds = us;
    w.val.status = st;
    dir_rows = {dir_rows, w};
  endtask

  // one well-formed map build with a few conversions, plus some noise
  task automatic random_sequence();
    logic [mtt_pkg::TickW-1:0] t;
    logic [mtt_pkg::TickW-1:0] nt;
    int n;
    if ($urandom_range(9) != 0) send(mtt_pkg::OpClear, $urandom, 24'($urandom));
    n = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
    t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 5000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: send(mtt_pkg::OpAppend, (t == 0) ? 32'd0 : $urandom_range(0, t - 1),
                24'($urandom));
        1: send(mtt_pkg::OpNone, $urandom, 24'($urandom));
        2: send(mtt_pkg::OpAppend, t, 24'($urandom)); // same tick again, tempo overwrite
        default: begin
          nt = t + (($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1 << 20));
          if (nt > t) t = nt;
          send(mtt_pkg::OpAppend, t, ($urandom_range(15) == 0) ? 24'd0 : 24'($urandom));
        end
      endcase
    end
    repeat ($urandom_range(2, 4)) begin
      if ($urandom_range(2) == 0) send(mtt_pkg::OpConvert, $urandom, '0);
      else send(mtt_pkg::OpConvert, $urandom_range(0, (t > 32'hFFFF_0000) ? t : t + 65536),
                24'($urandom));
    end
  endtask

  // fill the whole table, then hit the full, overwrite and order cases
  task automatic full_table_sequence();
    logic [mtt_pkg::TickW-1:0] t;
    send(mtt_pkg::OpClear, '0, '0);
    for (int i = 0; i < MaxChanges; i++) begin
      t = i * 16_000_000 + $urandom_range(0, 15_000_000);
      send(mtt_pkg::OpAppend, t, 24'($urandom));
    end
    send(mtt_pkg::OpAppend, 32'hFFFF_FFFF, 24'($urandom));
    send(mtt_pkg::OpAppend, t, 24'hFFFFFF);
    send(mtt_pkg::OpAppend, t - 1, 24'($urandom));
    send(mtt_pkg::OpConvert, 32'hFFFF_FFFF, '0);
    send(mtt_pkg::OpConvert, $urandom, '0);
  endtask

  initial begin
    logic [mtt_pkg::PpqnW-1:0]  cfg_ppqn [5];
    logic [mtt_pkg::TempoW-1:0] cfg_tempo [5];
    int phase_pct [5];

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the reset values: ppqn 480, default tempo 500000
    add_row(mtt_pkg::OpConvert, 32'd0, 24'd0, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'd480, 24'd0, 1'b1, 63'd500000, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b0, '0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpNone, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpAppend, 32'd960, 24'hFFFFFF, 1'b1, 63'd0, mtt_pkg::StOk);
    // equal tick overwrites
    add_row(mtt_pkg::OpAppend, 32'd960, 24'd1, 1'b1, 63'd0, mtt_pkg::StOk);
    // tick out of order
    add_row(mtt_pkg::OpAppend, 32'd100, 24'd7, 1'b1, 63'd0, mtt_pkg::StOrder);
    add_row(mtt_pkg::OpAppend, 32'd0, 24'hFFFFFF, 1'b1, 63'd0, mtt_pkg::StOrder);
    // query on the change
    add_row(mtt_pkg::OpConvert, 32'd960, 24'd0, 1'b1, 63'd1000000, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'd1440, 24'd0, 1'b1, 63'd1000001, mtt_pkg::StOk);
    // zero tempo segment
    add_row(mtt_pkg::OpAppend, 32'hFFFF_FFFF, 24'd0, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'hFFFF_FFFF, 24'd0, 1'b0, '0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'd961, 24'd0, 1'b0, '0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpClear, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1, 63'd0, mtt_pkg::StOk);
    // empty map again
    add_row(mtt_pkg::OpConvert, 32'd480, 24'd0, 1'b1, 63'd500000, mtt_pkg::StOk);
    add_row(mtt_pkg::OpAppend, 32'd0, 24'd1, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'd1, 24'd0, 1'b0, '0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpAppend, 32'd0, 24'hFFFFFF, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpConvert, 32'hFFFF_FFFF, 24'd0, 1'b0, '0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpNone, 32'd0, 24'd0, 1'b1, 63'd0, mtt_pkg::StOk);
    add_row(mtt_pkg::OpClear, 32'd0, 24'd0, 1'b1, 63'd0, mtt_pkg::StOk);
    foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].has, dir_rows[i].val);

    // register settings per phase, extremes first, zero ppqn and zero tempo included
    cfg_ppqn = '{15'd480, 15'd1, 15'd32767, 15'd0, 15'd96};
    cfg_tempo = '{24'd500000, 24'hFFFFFF, 24'd1, 24'd0, 24'd0};
    cfg_ppqn[4] = 15'($urandom);
    cfg_tempo[4] = 24'($urandom);
    phase_pct = '{26, 26, 54, 54, 0};

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(cfg_ppqn[ph], cfg_tempo[ph]);
      idle_pct = phase_pct[ph];
      if (ph == 1) full_table_sequence();
      while (req_count < 21 + (ph + 1) * 250) begin
        random_sequence();
        // now and then let everything settle before going on
        if ($urandom_range(15) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    mismatches += result_q.size();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mtt_pkg.sv
rtl/mtt_seg_div.sv
rtl/midi_tick_to_microsecond_tempo_map_top.sv
tb/tb.sv
